// ===== hw/rtl/kwv_pkg.sv =====
// Package for the Kaiser window value unit.
// Fixed-point constants and the divider request type; no dependencies.
`default_nettype none
package kwv_pkg;

  localparam int unsigned HW = 28;   // series half-argument width, Q.24
  localparam int unsigned YW = 50;   // series sum width, Q26.24
  localparam int unsigned MA = 28;   // multiplier operand a width
  localparam int unsigned MB = 33;   // multiplier operand b width
  localparam int unsigned MP = MA + MB;

  localparam logic [15:0] BETA_MAX   = 16'd40960;
  localparam logic [15:0] BETA_RESET = 16'd12288;
  localparam logic [YW-1:0] ONE_Q24  = YW'(64'd1 << 24);
  localparam logic [YW-1:0] MAX50    = {YW{1'b1}};
  localparam logic [16:0] UNITY_Q16  = 17'd65536;
  localparam logic [4:0]  TERM_DIV_STEPS  = 5'd28;
  localparam logic [4:0]  FINAL_DIV_STEPS = 5'd16;

  typedef struct packed {
    logic            start;
    logic [YW-1:0]   rem_init;
    logic [HW-1:0]   dividend;
    logic [4:0]      steps;
    logic [YW-1:0]   divisor;
  } div_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/kwv_mul.sv =====
// Shared 28x33 unsigned multiplier with registered product.
// Uses kwv_pkg widths.
`default_nettype none
module kwv_mul
  import kwv_pkg::*;
(
  input  wire logic          clk,
  input  wire logic [MA-1:0] a,
  input  wire logic [MB-1:0] b,
  output logic [MP-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= MP'(a) * MP'(b);
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kwv_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses kwv_pkg (div_req_t, widths).
`default_nettype none
module kwv_div
  import kwv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output logic          done,
  output logic [HW-1:0] quo
);

  logic [YW-1:0] rem;
  logic [HW-1:0] dvd;
  logic [4:0]    cnt;
  logic          busy;
  logic [YW:0]   trial;
  logic          fits;

  assign trial = {rem, dvd[HW-1]};
  assign fits  = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= req.steps;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? YW'(trial - {1'b0, req.divisor}) : trial[YW-1:0];
      dvd <= {dvd[HW-2:0], 1'b0};
      quo <= {quo[HW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/kaiser_window_value_unit.sv =====
// Kaiser window value unit: I0(beta*sqrt(1-(2x-1)^2)) / I0(beta), fixed point.
// One item at a time. Each series term runs the 28-step serial divide for h/i and then
// uses the shared multiplier; each item also runs the 17-step square root and, unless the
// series sum reaches I0(beta), the 16-step final divide.
// Reset and every beta write run the series for I0(beta), during which in_ready is low.
// Synchronous active-high reset; beta resets to 6.0.
`default_nettype none
module kaiser_window_value_unit
  import kwv_pkg::*;
#(
  parameter int unsigned SERIES_TERMS = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [16:0] position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      window_value,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  localparam int unsigned IW = $clog2(SERIES_TERMS + 1);

  typedef enum logic [17:0] {
    S_IDLE   = 18'b000000000000000001,
    S_SQ     = 18'b000000000000000010,
    S_SQRT   = 18'b000000000000000100,
    S_ZMUL   = 18'b000000000000001000,
    S_ZSET   = 18'b000000000000010000,
    S_BSTART = 18'b000000000000100000,
    S_TSTART = 18'b000000000001000000,
    S_TWAIT  = 18'b000000000010000000,
    S_QQ     = 18'b000000000100000000,
    S_Q2     = 18'b000000001000000000,
    S_ULO    = 18'b000000010000000000,
    S_UHI    = 18'b000000100000000000,
    S_UACC   = 18'b000001000000000000,
    S_ACC    = 18'b000010000000000000,
    S_FCHK   = 18'b000100000000000000,
    S_FSTART = 18'b001000000000000000,
    S_FWAIT  = 18'b010000000000000000,
    S_DONE   = 18'b100000000000000000
  } state_t;

  state_t        state;
  logic [15:0]   beta;
  logic [15:0]   beta_used;
  logic [YW-1:0] bessel;
  logic          is_den;
  logic          cfg_pend;
  logic [32:0]   rr;
  logic [32:0]   res;
  logic [32:0]   sbit;
  logic [HW-1:0] h;
  logic [HW-1:0] q;
  logic [32:0]   q2;
  logic [57:0]   plo;
  logic [YW-1:0] u;
  logic [YW-1:0] y;
  logic [IW-1:0] iter;
  logic [16:0]   result;

  logic [16:0]   psat;
  logic [17:0]   twice;
  logic [16:0]   tabs;
  logic [33:0]   sqrt_sum;
  logic [82:0]   ufull;
  logic [YW:0]   ysum;
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [MP-1:0] mul_p;
  div_req_t      dreq;
  logic          div_done;
  logic [HW-1:0] div_quo;

  assign beta_used = (beta > BETA_MAX) ? BETA_MAX : beta;
  assign psat      = (position > UNITY_Q16) ? UNITY_Q16 : position;
  assign twice     = {psat, 1'b0};
  assign tabs      = (twice >= 18'd65536) ? 17'(twice - 18'd65536) : 17'(18'd65536 - twice);
  assign sqrt_sum  = {1'b0, res} + {1'b0, sbit};
  assign ufull     = {mul_p[57:0], 25'b0} + {25'b0, plo};
  assign ysum      = {1'b0, y} + {1'b0, u};
  assign in_ready  = (state == S_IDLE) && !cfg_wr_en && !cfg_pend;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_IDLE: begin
        mul_a = MA'(tabs);
        mul_b = MB'(tabs);
      end
      S_ZMUL: begin
        mul_a = MA'(beta_used);
        mul_b = MB'(res[16:0]);
      end
      S_QQ: begin
        mul_a = q;
        mul_b = MB'(q);
      end
      S_ULO: begin
        mul_a = MA'(u[24:0]);
        mul_b = q2;
      end
      S_UHI: begin
        mul_a = MA'(u[49:25]);
        mul_b = q2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.rem_init = '0;
    dreq.dividend = h;
    dreq.steps    = TERM_DIV_STEPS;
    dreq.divisor  = YW'(iter);
    if (state == S_TSTART) begin
      dreq.start = 1'b1;
    end else if (state == S_FSTART || state == S_FWAIT) begin
      dreq.start    = (state == S_FSTART);
      dreq.rem_init = y;
      dreq.dividend = '0;
      dreq.steps    = FINAL_DIV_STEPS;
      dreq.divisor  = bessel;
    end
  end

  kwv_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  kwv_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BSTART;
      beta      <= BETA_RESET;
      out_valid <= 1'b0;
      is_den    <= 1'b1;
      cfg_pend  <= 1'b0;
      iter      <= '0;
    end else begin
      if (cfg_wr_en) begin
        beta <= cfg_wr_data;
      end
      // a write while busy reruns the I0(beta) series once back in idle
      cfg_pend <= cfg_wr_en ? (state != S_IDLE) : (cfg_pend && state != S_BSTART);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_wr_en || cfg_pend) begin
            state <= S_BSTART;
          end else if (in_valid) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          rr    <= (mul_p[33:32] != 2'b00) ? 33'd0 : (33'd1 << 32) - {1'b0, mul_p[31:0]};
          res   <= '0;
          sbit  <= 33'd1 << 32;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if ({1'b0, rr} >= sqrt_sum) begin
            rr  <= 33'({1'b0, rr} - sqrt_sum);
            res <= (res >> 1) + sbit;
          end else begin
            res <= res >> 1;
          end
          sbit <= sbit >> 2;
          if (sbit[0]) begin
            state <= S_ZMUL;
          end
        end
        S_ZMUL: begin
          state <= S_ZSET;
        end
        S_ZSET: begin
          h      <= mul_p[31:4];
          is_den <= 1'b0;
          u      <= ONE_Q24;
          y      <= ONE_Q24;
          iter   <= IW'(1);
          state  <= S_TSTART;
        end
        S_BSTART: begin
          h      <= {beta_used, 12'b0};
          is_den <= 1'b1;
          u      <= ONE_Q24;
          y      <= ONE_Q24;
          iter   <= IW'(1);
          state  <= S_TSTART;
        end
        S_TSTART: begin
          state <= S_TWAIT;
        end
        S_TWAIT: begin
          if (div_done) begin
            q     <= div_quo;
            state <= S_QQ;
          end
        end
        S_QQ: begin
          state <= S_Q2;
        end
        S_Q2: begin
          q2    <= mul_p[56:24];
          state <= S_ULO;
        end
        S_ULO: begin
          state <= S_UHI;
        end
        S_UHI: begin
          plo   <= mul_p[57:0];
          state <= S_UACC;
        end
        S_UACC: begin
          u     <= (|ufull[82:74]) ? MAX50 : ufull[73:24];
          state <= S_ACC;
        end
        S_ACC: begin
          y <= ysum[YW] ? MAX50 : ysum[YW-1:0];
          if (iter == IW'(SERIES_TERMS)) begin
            if (is_den) begin
              bessel <= ysum[YW] ? MAX50 : ysum[YW-1:0];
              state  <= S_IDLE;
            end else begin
              state <= S_FCHK;
            end
          end else begin
            iter  <= iter + IW'(1);
            state <= S_TSTART;
          end
        end
        S_FCHK: begin
          if (bessel == '0 || y >= bessel) begin
            result <= UNITY_Q16;
            state  <= S_DONE;
          end else begin
            state <= S_FSTART;
          end
        end
        S_FSTART: begin
          state <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            result <= {1'b0, div_quo[15:0]};
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            window_value <= result;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_TWAIT || state == S_FWAIT))
    else $error("divider finished outside a wait state");

  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_TWAIT) |-> (iter >= IW'(1) && iter <= IW'(SERIES_TERMS)))
    else $error("series term index out of range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_value <= UNITY_Q16))
    else $error("window value above unity");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cfg_wr_en) |=> !in_ready)
    else $error("beta write did not start the I0(beta) series");

endmodule
`default_nettype wire

// ===== tb/kaiser_window_value_unit_tb.sv =====
// Self-checking testbench for kaiser_window_value_unit: window gain for a position and beta.
// The expected gains come from a bit-exact fixed-point Bessel I0 series model held here.
// Depends on kwv_pkg and the RTL only.
`timescale 1ns / 100ps
`default_nettype none
module kaiser_window_value_unit_tb;
  import kwv_pkg::*;

  localparam int unsigned TERMS = 48;

  class gain_scoreboard;
    logic [15:0] beta_reg;
    logic [63:0] i0_of_beta;
    logic [16:0] gain_q[$];
    int unsigned errors;

    function logic [63:0] mul_q24(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:88] != 0) return '1;
      return p[87:24];
    endfunction

    function logic [63:0] bessel_i0(logic [63:0] z);
      logic [63:0] half, q, y, u;
      half = z >> 1;
      y = 64'(ONE_Q24);
      u = 64'(ONE_Q24);
      for (int i = 1; i <= TERMS; i++) begin
        q = half / 64'(i);
        u = mul_q24(u, mul_q24(q, q));
        if (u > 64'(MAX50)) u = 64'(MAX50);
        y = y + u;
        if (y > 64'(MAX50)) y = 64'(MAX50);
      end
      return y;
    endfunction

    function logic [63:0] isqrt(logic [63:0] r);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > r) b = b >> 2;
      while (b != 0) begin
        if (r >= res + b) begin
          r = r - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function logic [63:0] beta_sat();
      return (beta_reg > BETA_MAX) ? 64'(BETA_MAX) : 64'(beta_reg);
    endfunction

    function void set_beta(logic [15:0] b);
      beta_reg = b;
      i0_of_beta = bessel_i0(beta_sat() << 13);
    endfunction

    function new();
      errors = 0;
      set_beta(BETA_RESET);
    endfunction

    function void note_position(logic [16:0] pos);
      logic [63:0] p, tabs, sq, r, num;
      logic [79:0] n;
      logic [16:0] g;
      p = (pos > 17'd65536) ? 64'd65536 : 64'(pos);
      tabs = (2 * p >= 64'd65536) ? 2 * p - 64'd65536 : 64'd65536 - 2 * p;
      sq = tabs * tabs;
      r = (sq >= (64'd1 << 32)) ? 64'd0 : (64'd1 << 32) - sq;
      num = bessel_i0((beta_sat() * isqrt(r)) >> 3);
      if (i0_of_beta == 0 || num >= i0_of_beta) begin
        g = UNITY_Q16;
      end else begin
        n = {num[63:0], 16'd0};
        g = 17'(n / {16'd0, i0_of_beta});
      end
      gain_q.push_back(g);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_gain(logic [16:0] got);
      logic [16:0] want;
      if (gain_q.size() == 0) begin
        report($sformatf("unexpected item, gain %0d", got));
      end else begin
        want = gain_q.pop_front();
        if (got !== want) report($sformatf("gain %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [16:0] position = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [16:0] window_value;
  logic cfg_wr_en = 0;
  logic [15:0] cfg_wr_data = 0;
  logic long_hold = 0;

  gain_scoreboard sb = new();

  kaiser_window_value_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .position(position),
    .out_valid(out_valid), .out_ready(out_ready), .window_value(window_value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_gain(window_value);
  end

  // receiver: stall pattern changes mode every so often; one long hold on request
  initial begin
    int hold_cnt, mode_cnt, mode;
    bit long_taken;
    hold_cnt = 0;
    mode_cnt = 0;
    mode = 0;
    long_taken = 0;
    forever begin
      @(posedge clk);
      if (long_hold && !long_taken) begin
        hold_cnt = 6000;
        long_taken = 1;
      end
      if (mode_cnt == 0) begin
        mode = $urandom_range(0, 2);
        mode_cnt = $urandom_range(50, 3000);
      end
      mode_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 0;
      end else if (mode == 0) begin
        out_ready <= 1;
      end else if (mode == 1) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    end
  end

  task send_item(logic [16:0] pos);
    in_valid <= 1;
    position <= pos;
    do @(posedge clk); while (!in_ready);
    sb.note_position(pos);
  endtask

  task idle_sender(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task wait_drained();
    idle_sender(1);
    while (sb.gain_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_beta(logic [15:0] b);
    cfg_wr_en <= 1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.set_beta(b);
  endtask

  function logic [16:0] rand_position();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return 17'($urandom_range(0, 131071));
    if (k == 1) return 17'($urandom_range(65530, 65536));
    if (k == 2) return 17'($urandom_range(0, 6));
    return 17'($urandom_range(0, 65536));
  endfunction

  task random_burst(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && left > 0) begin
        send_item(rand_position());
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 400));
    end
  endtask

  initial begin
    logic [16:0] edge_pos[9];
    logic [15:0] betas[6];
    edge_pos = '{17'd0, 17'd1, 17'd16384, 17'd32767, 17'd32768,
                 17'd49152, 17'd65535, 17'd65536, 17'd131071};
    betas = '{16'd0, 16'd40960, 16'd65535, 16'd1, 16'd20480, 16'd40959};
    repeat (2) @(posedge clk);
    rst <= 0;

    // reset beta of 6.0
    foreach (edge_pos[i]) send_item(edge_pos[i]);
    wait_drained();
    write_beta(16'd0);
    send_item(17'd32768);
    send_item(17'd0);
    wait_drained();
    write_beta(16'd65535);
    send_item(17'd32768);
    send_item(17'd100);
    send_item(17'd70000);
    wait_drained();
    write_beta(BETA_MAX);
    send_item(17'd1);
    send_item(17'd32768);
    wait_drained();

    long_hold <= 1;
    random_burst(20);
    long_hold <= 0;
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 6) write_beta(betas[ph]);
      else write_beta(16'($urandom_range(0, 40960)));
      random_burst(210);
      wait_drained();
    end
    write_beta(16'($urandom_range(0, 65535)));
    random_burst(20);
    wait_drained();

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.gain_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #500000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
